// ===== sv/laser_scan_obstacle_summary_assert.svh =====
`ifndef LASER_SCAN_OBSTACLE_SUMMARY_ASSERT_SVH
`define LASER_SCAN_OBSTACLE_SUMMARY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LSOS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LSOS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lsos_pkg.sv =====
package lsos_pkg;

   localparam int NUM_BEAMS_DEF = 640;

   localparam int RANGE_W   = 17;
   localparam int IDX_W     = 11;
   localparam int FIRST_W   = 10;
   localparam int CSR_IDX_W = 3;

   localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

   // register reset values
   localparam logic [RANGE_W-1:0] OBJECT_BAND_RST   = 17'd200;
   localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST    = 17'd1500;
   localparam logic [RANGE_W-1:0] INVALID_LIMIT_RST = 17'd100000;
   localparam logic [FIRST_W-1:0] FRONT_FIRST_RST   = 10'd200;
   localparam logic [IDX_W-1:0]   FRONT_END_RST     = 11'd336;
   localparam logic [IDX_W-1:0]   RIGHT_END_RST     = 11'd100;
   localparam logic [FIRST_W-1:0] LEFT_FIRST_RST    = 10'd539;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_BAND   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_FIRST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_END     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_END     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_FIRST    = 3'd6;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/lsos_ram.sv =====
module lsos_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 640
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/lsos_div.sv =====
module lsos_div #(
   parameter int NW = 28,
   parameter int DW = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NW-1:0]              dividend,
   input  logic [DW-1:0]              divisor,
   output logic [NW-1:0]              quotient,
   output lsos_pkg::div_stat_type     status
);

   localparam int IW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          fits;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = IW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - IW'(1);
         if (cnt_ff == IW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sv/laser_scan_obstacle_summary.sv =====
// Laser scan obstacle summary.
// Input channel req_*: one word per beam, range in mm plus a last-beam flag.
// Beams are written into the beam RAM in arrival order; beams beyond
// NUM_BEAMS are dropped, but a dropped last beam still closes the scan.
// Output channel rsp_*: one summary word per scan (closest range, object
// edges, front minimum, left and right sector means with ok flags).
// Configuration port csr_*: one write per cycle, register index csr_index;
// write only while no scan is being summarized.
// Throughput: one beam per cycle while loading (req_ready high).
// After the last beam, req_ready drops while the summary is built:
//   pass 1 over the RAM (closest, front min, sector sums),
//   pass 2 for object edges, only when closest is within the near limit,
//   then two mean divisions on one shared bit-serial divider, and finally
//   the load of the output register.
// The summary sits in an output register: a stalled receiver holds it while
// the next scan loads; the block only waits if that next summary is ready
// before the previous one was taken.
// Reset (synchronous) clears the beam count, empties the output register and
// restores the register defaults; the RAM keeps its contents.
module laser_scan_obstacle_summary #(
   parameter int NUM_BEAMS = lsos_pkg::NUM_BEAMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsos_pkg::RANGE_W-1:0]        req_range_mm,
   input  logic                                req_last_beam,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lsos_pkg::IDX_W-1:0]   rsp_object_left_beam,
   output logic signed [lsos_pkg::IDX_W-1:0]   rsp_object_right_beam,
   output logic [lsos_pkg::RANGE_W-1:0]        rsp_closest_mm,
   output logic [lsos_pkg::RANGE_W-1:0]        rsp_front_min_mm,
   output logic [lsos_pkg::RANGE_W-1:0]        rsp_left_mean_mm,
   output logic                                rsp_left_mean_ok,
   output logic [lsos_pkg::RANGE_W-1:0]        rsp_right_mean_mm,
   output logic                                rsp_right_mean_ok,

   input  logic                                csr_we,
   input  logic [lsos_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsos_pkg::RANGE_W-1:0]        csr_wdata
);

   localparam int RW    = lsos_pkg::RANGE_W;
   localparam int XW    = lsos_pkg::IDX_W;
   localparam int FW    = lsos_pkg::FIRST_W;
   localparam int AW    = $clog2(NUM_BEAMS);
   localparam int CW    = $clog2(NUM_BEAMS + 1);
   localparam int CMP_W = (CW > XW) ? CW : XW;
   localparam int SUM_W = RW + CW;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_SCAN1 = 3'd1;
   localparam logic [2:0] ST_SCAN2 = 3'd2;
   localparam logic [2:0] ST_DIVL  = 3'd3;
   localparam logic [2:0] ST_DIVR  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // configuration
   logic [RW-1:0] band_ff, near_ff, inv_ff;
   logic [FW-1:0] ffirst_ff, lfirst_ff;
   logic [XW-1:0] fend_ff, rend_ff;

   // control
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, count_next;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] p_idx_ff;
   logic          p_valid_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   // scan accumulators
   logic [RW-1:0]    closest_ff, closest_in;
   logic [RW-1:0]    front_ff, front_in;
   logic [SUM_W-1:0] lsum_ff, lsum_in, rsum_ff, rsum_in;
   logic [CW-1:0]    lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [RW:0]      obj_band_ff, obj_band_in;
   logic             found_r_ff, found_r_in, found_l_ff, found_l_in;
   logic [XW-1:0]    left_ff, left_in, right_ff, right_in;
   logic [RW-1:0]    lmean_ff, lmean_in, rmean_ff, rmean_in;
   logic             lok_ff, lok_in, rok_ff, rok_in;

   // output register payload
   logic [XW-1:0] o_left_ff, o_left_in, o_right_ff, o_right_in;
   logic [RW-1:0] o_closest_ff, o_closest_in, o_front_ff, o_front_in;
   logic [RW-1:0] o_lmean_ff, o_lmean_in, o_rmean_ff, o_rmean_in;
   logic          o_lok_ff, o_lok_in, o_rok_ff, o_rok_in;

   // datapath
   logic                   accept_req;
   logic                   store_room;
   logic                   scanning;
   logic                   issue;
   logic                   scan_end;
   logic                   slot_free;
   logic [RW-1:0]          rdata;
   logic [CMP_W-1:0]       jx;
   logic                   in_front, valid_beam, within_band;
   logic                   div_start, div_sel_right;
   logic [SUM_W-1:0]       div_dividend, div_quo;
   logic [CW-1:0]          div_divisor;
   lsos_pkg::div_stat_type div_stat;

   assign req_ready  = (state_ff == ST_LOAD);
   assign accept_req = req_valid && req_ready;
   assign store_room = count_ff < CW'(NUM_BEAMS);
   assign count_next = store_room ? count_ff + CW'(1) : count_ff;

   // one RAM read issued per cycle during a pass; data returns next cycle
   assign scanning = (state_ff == ST_SCAN1) || (state_ff == ST_SCAN2);
   assign issue    = scanning && (rd_ptr_ff < n_ff);
   assign scan_end = scanning && !issue && !p_valid_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   lsos_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_BEAMS)
   ) u_beam_ram (
      .clock (clock),
      .we    (accept_req && store_room),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_range_mm),
      .raddr (rd_ptr_ff[AW-1:0]),
      .rdata (rdata)
   );

   assign jx          = CMP_W'(p_idx_ff);
   assign in_front    = (jx >= CMP_W'(ffirst_ff)) && (jx < CMP_W'(fend_ff));
   assign valid_beam  = rdata < inv_ff;
   assign within_band = {1'b0, rdata} <= obj_band_ff;

   // left mean first, then right mean on the same divider
   assign div_sel_right = (state_ff == ST_DIVL);
   assign div_dividend  = div_sel_right ? rsum_ff : lsum_ff;
   assign div_divisor   = div_sel_right ? rcnt_ff : lcnt_ff;
   assign div_start     = (scan_end && !div_stat.busy
                           && ((state_ff == ST_SCAN2) || (closest_ff > near_ff)))
                          || ((state_ff == ST_DIVL) && div_stat.done);

   lsos_div #(
      .NW (SUM_W),
      .DW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      rd_ptr_in    = issue ? rd_ptr_ff + CW'(1) : rd_ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      closest_in   = closest_ff;
      front_in     = front_ff;
      lsum_in      = lsum_ff;
      lcnt_in      = lcnt_ff;
      rsum_in      = rsum_ff;
      rcnt_in      = rcnt_ff;
      obj_band_in  = obj_band_ff;
      found_r_in   = found_r_ff;
      found_l_in   = found_l_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      lmean_in     = lmean_ff;
      lok_in       = lok_ff;
      rmean_in     = rmean_ff;
      rok_in       = rok_ff;
      o_left_in    = o_left_ff;
      o_right_in   = o_right_ff;
      o_closest_in = o_closest_ff;
      o_front_in   = o_front_ff;
      o_lmean_in   = o_lmean_ff;
      o_lok_in     = o_lok_ff;
      o_rmean_in   = o_rmean_ff;
      o_rok_in     = o_rok_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept_req) begin
               if (req_last_beam) begin
                  // close the scan and arm pass 1
                  n_in       = count_next;
                  count_in   = '0;
                  rd_ptr_in  = '0;
                  closest_in = inv_ff;
                  front_in   = lsos_pkg::RANGE_MAX;
                  lsum_in    = '0;
                  lcnt_in    = '0;
                  rsum_in    = '0;
                  rcnt_in    = '0;
                  left_in    = '1;
                  right_in   = '1;
                  state_in   = ST_SCAN1;
               end else begin
                  count_in = count_next;
               end
            end
         end
         ST_SCAN1: begin
            if (p_valid_ff) begin
               if (rdata < closest_ff) begin
                  closest_in = rdata;
               end
               if (in_front && (rdata < front_ff)) begin
                  front_in = rdata;
               end
               if (valid_beam && (jx >= CMP_W'(lfirst_ff))) begin
                  lsum_in = lsum_ff + SUM_W'(rdata);
                  lcnt_in = lcnt_ff + CW'(1);
               end
               if (valid_beam && (jx < CMP_W'(rend_ff))) begin
                  rsum_in = rsum_ff + SUM_W'(rdata);
                  rcnt_in = rcnt_ff + CW'(1);
               end
            end
            if (scan_end) begin
               obj_band_in = {1'b0, closest_ff} + {1'b0, band_ff};
               found_r_in  = 1'b0;
               found_l_in  = 1'b0;
               rd_ptr_in   = '0;
               state_in    = (closest_ff <= near_ff) ? ST_SCAN2 : ST_DIVL;
            end
         end
         ST_SCAN2: begin
            // right edge: first beam inside the band; left edge: beam before
            // the next valid reading above the band
            if (p_valid_ff) begin
               if (!found_r_ff) begin
                  if (within_band) begin
                     right_in   = XW'(p_idx_ff);
                     found_r_in = 1'b1;
                  end
               end else if (!found_l_ff && !within_band && valid_beam) begin
                  left_in    = XW'(p_idx_ff) - XW'(1);
                  found_l_in = 1'b1;
               end
            end
            if (scan_end) begin
               state_in = ST_DIVL;
            end
         end
         ST_DIVL: begin
            if (div_stat.done) begin
               lok_in   = (lcnt_ff != '0);
               lmean_in = (lcnt_ff != '0) ? div_quo[RW-1:0] : '0;
               state_in = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (div_stat.done) begin
               rok_in   = (rcnt_ff != '0);
               rmean_in = (rcnt_ff != '0) ? div_quo[RW-1:0] : '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free, then hand over
            if (slot_free) begin
               o_left_in    = left_ff;
               o_right_in   = right_ff;
               o_closest_in = closest_ff;
               o_front_in   = front_ff;
               o_lmean_in   = lmean_ff;
               o_lok_in     = lok_ff;
               o_rmean_in   = rmean_ff;
               o_rok_in     = rok_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         band_ff      <= lsos_pkg::OBJECT_BAND_RST;
         near_ff      <= lsos_pkg::NEAR_LIMIT_RST;
         inv_ff       <= lsos_pkg::INVALID_LIMIT_RST;
         ffirst_ff    <= lsos_pkg::FRONT_FIRST_RST;
         fend_ff      <= lsos_pkg::FRONT_END_RST;
         rend_ff      <= lsos_pkg::RIGHT_END_RST;
         lfirst_ff    <= lsos_pkg::LEFT_FIRST_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         p_valid_ff   <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               lsos_pkg::CSR_OBJECT_BAND:   band_ff   <= csr_wdata;
               lsos_pkg::CSR_NEAR_LIMIT:    near_ff   <= csr_wdata;
               lsos_pkg::CSR_INVALID_LIMIT: inv_ff    <= csr_wdata;
               lsos_pkg::CSR_FRONT_FIRST:   ffirst_ff <= csr_wdata[FW-1:0];
               lsos_pkg::CSR_FRONT_END:     fend_ff   <= csr_wdata[XW-1:0];
               lsos_pkg::CSR_RIGHT_END:     rend_ff   <= csr_wdata[XW-1:0];
               lsos_pkg::CSR_LEFT_FIRST:    lfirst_ff <= csr_wdata[FW-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      rd_ptr_ff    <= rd_ptr_in;
      p_idx_ff     <= rd_ptr_ff;
      closest_ff   <= closest_in;
      front_ff     <= front_in;
      lsum_ff      <= lsum_in;
      lcnt_ff      <= lcnt_in;
      rsum_ff      <= rsum_in;
      rcnt_ff      <= rcnt_in;
      obj_band_ff  <= obj_band_in;
      found_r_ff   <= found_r_in;
      found_l_ff   <= found_l_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      lmean_ff     <= lmean_in;
      lok_ff       <= lok_in;
      rmean_ff     <= rmean_in;
      rok_ff       <= rok_in;
      o_left_ff    <= o_left_in;
      o_right_ff   <= o_right_in;
      o_closest_ff <= o_closest_in;
      o_front_ff   <= o_front_in;
      o_lmean_ff   <= o_lmean_in;
      o_lok_ff     <= o_lok_in;
      o_rmean_ff   <= o_rmean_in;
      o_rok_ff     <= o_rok_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_object_left_beam  = o_left_ff;
   assign rsp_object_right_beam = o_right_ff;
   assign rsp_closest_mm        = o_closest_ff;
   assign rsp_front_min_mm      = o_front_ff;
   assign rsp_left_mean_mm      = o_lmean_ff;
   assign rsp_left_mean_ok      = o_lok_ff;
   assign rsp_right_mean_mm     = o_rmean_ff;
   assign rsp_right_mean_ok     = o_rok_ff;

endmodule

// ===== sv/lsos_checker.sv =====
`include "laser_scan_obstacle_summary_assert.svh"

module lsos_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lsos_pkg::IDX_W-1:0]        rsp_object_left_beam,
   input logic [lsos_pkg::IDX_W-1:0]        rsp_object_right_beam,
   input logic [lsos_pkg::RANGE_W-1:0]      rsp_closest_mm,
   input logic [lsos_pkg::RANGE_W-1:0]      rsp_left_mean_mm,
   input logic                              rsp_left_mean_ok,
   input logic [lsos_pkg::RANGE_W-1:0]      rsp_right_mean_mm,
   input logic                              rsp_right_mean_ok
);

   `LSOS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "summary word dropped while stalled")
   `LSOS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_closest_mm) && $stable(rsp_object_right_beam), "summary word changed while stalled")
   `LSOS_ASSERT_NOW(a_edges, clock, reset, rsp_valid && (rsp_object_right_beam == {lsos_pkg::IDX_W{1'b1}}), rsp_object_left_beam == {lsos_pkg::IDX_W{1'b1}}, "left edge reported without right edge")
   `LSOS_ASSERT_NOW(a_left_empty, clock, reset, rsp_valid && !rsp_left_mean_ok, rsp_left_mean_mm == '0, "left mean nonzero for empty sector")
   `LSOS_ASSERT_NOW(a_right_empty, clock, reset, rsp_valid && !rsp_right_mean_ok, rsp_right_mean_mm == '0, "right mean nonzero for empty sector")

endmodule

bind laser_scan_obstacle_summary lsos_checker u_lsos_checker (.*);

// ===== test/tb_laser_scan_obstacle_summary.sv =====
module tb_laser_scan_obstacle_summary;
   import lsos_pkg::*;

   localparam int NUM_BEAMS   = NUM_BEAMS_DEF;
   localparam int CYCLE_LIMIT = 1000000;

   // One beam word as it goes out on the req_ channel.
   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic               last_beam;
   } beam_word_type;

   // One scan summary as it comes back on the rsp_ channel.
   typedef struct packed {
      logic [IDX_W-1:0]   left_beam;
      logic [IDX_W-1:0]   right_beam;
      logic [RANGE_W-1:0] closest;
      logic [RANGE_W-1:0] front_min;
      logic [RANGE_W-1:0] left_mean;
      logic               left_ok;
      logic [RANGE_W-1:0] right_mean;
      logic               right_ok;
   } scan_summary_type;

   // Drive every input to a known value from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [RANGE_W-1:0] req_range_mm  = '0;
   logic               req_last_beam = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [IDX_W-1:0]   rsp_object_left_beam;
   logic signed [IDX_W-1:0]   rsp_object_right_beam;
   logic [RANGE_W-1:0]        rsp_closest_mm;
   logic [RANGE_W-1:0]        rsp_front_min_mm;
   logic [RANGE_W-1:0]        rsp_left_mean_mm;
   logic                      rsp_left_mean_ok;
   logic [RANGE_W-1:0]        rsp_right_mean_mm;
   logic                      rsp_right_mean_ok;

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RANGE_W-1:0]   csr_wdata = '0;

   laser_scan_obstacle_summary dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_range_mm          (req_range_mm),
      .req_last_beam         (req_last_beam),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_object_left_beam  (rsp_object_left_beam),
      .rsp_object_right_beam (rsp_object_right_beam),
      .rsp_closest_mm        (rsp_closest_mm),
      .rsp_front_min_mm      (rsp_front_min_mm),
      .rsp_left_mean_mm      (rsp_left_mean_mm),
      .rsp_left_mean_ok      (rsp_left_mean_ok),
      .rsp_right_mean_mm     (rsp_right_mean_mm),
      .rsp_right_mean_ok     (rsp_right_mean_ok),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the block: its registers and its beam store.
   // Registers are only written while the block is idle, so the shadow
   // can take a new value as soon as the write is driven.
   // ------------------------------------------------------------------
   logic [RANGE_W-1:0] cfg_band;
   logic [RANGE_W-1:0] cfg_near;
   logic [RANGE_W-1:0] cfg_invalid;
   logic [FIRST_W-1:0] cfg_front_first;
   logic [IDX_W-1:0]   cfg_front_end;
   logic [IDX_W-1:0]   cfg_right_end;
   logic [FIRST_W-1:0] cfg_left_first;

   logic [RANGE_W-1:0] beam_mem [0:NUM_BEAMS-1];
   int                 beam_fill;
   int                 scan_words;

   beam_word_type    beam_words_q [$];   // words waiting to be driven
   scan_summary_type summary_q [$];      // summaries owed by the block

   int beams_queued;
   int beams_accepted;
   int scans_checked;
   int settings_count;
   int longest_scan;
   int mismatch_count;
   bit steady_flow;                  // set: no idling on either side

   beam_word_type next_word;
   int            send_gap;
   int            take_gap;
   int            cycle_count;

   // Compute the summary of the n beams now in the store.
   function automatic scan_summary_type summarize_scan(int n);
      scan_summary_type   s;
      logic [RANGE_W:0]   band;
      logic [RANGE_W-1:0] nearest;
      longint unsigned    lsum, lcnt, rsum, rcnt;
      int                 i, fend, rend;
      s = '0;
      s.left_beam  = '1;
      s.right_beam = '1;

      // Closest return, seeded with the invalid limit.
      nearest = cfg_invalid;
      for (i = 0; i < n; i++)
         if (beam_mem[i] < nearest) nearest = beam_mem[i];
      s.closest = nearest;

      // Object edges: first beam inside the band, then the beam before the
      // next valid reading that leaves the band.
      if (nearest <= cfg_near) begin
         band = {1'b0, nearest} + {1'b0, cfg_band};
         i = 0;
         while (i < n && {1'b0, beam_mem[i]} > band) i++;
         if (i < n) begin
            s.right_beam = IDX_W'(i);
            while (i < n && !({1'b0, beam_mem[i]} > band && beam_mem[i] < cfg_invalid))
               i++;
            if (i < n) s.left_beam = IDX_W'(i - 1);
         end
      end

      // Front minimum, clipped to the scan; empty sector leaves all ones.
      s.front_min = RANGE_MAX;
      fend = (int'(cfg_front_end) < n) ? int'(cfg_front_end) : n;
      for (i = int'(cfg_front_first); i < fend; i++)
         if (beam_mem[i] < s.front_min) s.front_min = beam_mem[i];

      // Sector means over valid readings only, truncated.
      lsum = 0; lcnt = 0; rsum = 0; rcnt = 0;
      for (i = int'(cfg_left_first); i < n; i++)
         if (beam_mem[i] < cfg_invalid) begin
            lsum += beam_mem[i];
            lcnt++;
         end
      rend = (int'(cfg_right_end) < n) ? int'(cfg_right_end) : n;
      for (i = 0; i < rend; i++)
         if (beam_mem[i] < cfg_invalid) begin
            rsum += beam_mem[i];
            rcnt++;
         end
      if (lcnt != 0) begin
         s.left_mean = RANGE_W'(lsum / lcnt);
         s.left_ok   = 1'b1;
      end
      if (rcnt != 0) begin
         s.right_mean = RANGE_W'(rsum / rcnt);
         s.right_ok   = 1'b1;
      end
      return s;
   endfunction

   // Store one accepted beam; on the last beam, owe a summary and rewind.
   task automatic absorb_beam(logic [RANGE_W-1:0] r, logic last);
      if (beam_fill < NUM_BEAMS) begin
         beam_mem[beam_fill] = r;
         beam_fill++;
      end
      scan_words++;
      if (last) begin
         summary_q.insert(summary_q.size(), summarize_scan(beam_fill));
         if (scan_words > longest_scan) longest_scan = scan_words;
         beam_fill  = 0;
         scan_words = 0;
      end
   endtask

   // Mostly short gaps, a few long ones; none while steady_flow is set.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Driver: hold the word until it is taken, then wait out the gap and
   // present the next one from the pending queue.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_beam(req_range_mm, req_last_beam);
            beams_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (beam_words_q.size() != 0) begin
               next_word = beam_words_q.pop_front();
               req_range_mm  <= next_word.range_mm;
               req_last_beam <= next_word.last_beam;
               req_valid     <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Report one field; print only the first ten mismatches.
   task automatic check_field(string what, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("scan %0d %s: expected %0d, got %0d", scans_checked, what, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: stall the summary channel at random and compare each taken
   // word with the oldest summary owed.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      scan_summary_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (summary_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("summary word with no scan pending, closest %0d", rsp_closest_mm);
            end else begin
               want = summary_q.pop_front();
               check_field("object_left_beam", int'($signed(want.left_beam)),
                           int'(rsp_object_left_beam));
               check_field("object_right_beam", int'($signed(want.right_beam)),
                           int'(rsp_object_right_beam));
               check_field("closest_mm", want.closest, rsp_closest_mm);
               check_field("front_min_mm", want.front_min, rsp_front_min_mm);
               check_field("left_mean_mm", want.left_mean, rsp_left_mean_mm);
               check_field("left_mean_ok", want.left_ok, rsp_left_mean_ok);
               check_field("right_mean_mm", want.right_mean, rsp_right_mean_mm);
               check_field("right_mean_ok", want.right_ok, rsp_right_mean_ok);
            end
            scans_checked++;
            take_gap = pick_gap();
         end else if (take_gap != 0) begin
            take_gap--;
         end else if (!rsp_valid && $urandom_range(0, 19) == 0) begin
            take_gap = pick_gap();
         end
         rsp_ready <= (take_gap == 0);
      end
   end

   // Hard stop on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d summaries still owed",
                  cycle_count, summary_q.size());
         $display("laser_scan_obstacle_summary verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic int unsigned clamp_range(longint v);
      if (v < 0) return 0;
      if (v > RANGE_MAX) return RANGE_MAX;
      return 32'(v);
   endfunction

   task automatic queue_beam(int unsigned r, logic last);
      beam_word_type w;
      w.range_mm  = RANGE_W'(r);
      w.last_beam = last;
      beam_words_q.insert(beam_words_q.size(), w);
      beams_queued++;
   endtask

   // Drive one register; bits above the register's width carry noise.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      logic [RANGE_W-1:0] data;
      data = RANGE_W'($urandom);
      case (idx)
         CSR_OBJECT_BAND: begin
            data = RANGE_W'(val);
            cfg_band = data;
         end
         CSR_NEAR_LIMIT: begin
            data = RANGE_W'(val);
            cfg_near = data;
         end
         CSR_INVALID_LIMIT: begin
            data = RANGE_W'(val);
            cfg_invalid = data;
         end
         CSR_FRONT_FIRST: begin
            data[FIRST_W-1:0] = FIRST_W'(val);
            cfg_front_first = data[FIRST_W-1:0];
         end
         CSR_FRONT_END: begin
            data[IDX_W-1:0] = IDX_W'(val);
            cfg_front_end = data[IDX_W-1:0];
         end
         CSR_RIGHT_END: begin
            data[IDX_W-1:0] = IDX_W'(val);
            cfg_right_end = data[IDX_W-1:0];
         end
         CSR_LEFT_FIRST: begin
            data[FIRST_W-1:0] = FIRST_W'(val);
            cfg_left_first = data[FIRST_W-1:0];
         end
         default: ;
      endcase
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write all seven registers back to back, then release the port.
   task automatic write_setting(int unsigned band, int unsigned near_mm,
                                int unsigned inv, int unsigned ffirst,
                                int unsigned fend, int unsigned rend,
                                int unsigned lfirst);
      write_csr(CSR_OBJECT_BAND, band);
      write_csr(CSR_NEAR_LIMIT, near_mm);
      write_csr(CSR_INVALID_LIMIT, inv);
      write_csr(CSR_FRONT_FIRST, ffirst);
      write_csr(CSR_FRONT_END, fend);
      write_csr(CSR_RIGHT_END, rend);
      write_csr(CSR_LEFT_FIRST, lfirst);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // One scan: a run of beams on an object near the band edges, the rest
   // far returns, no-returns at and around the invalid limit, and noise.
   task automatic queue_scan(int len);
      int unsigned obj_lo, v;
      int          run_first, run_last, i;
      if ($urandom_range(0, 4) == 0) obj_lo = $urandom_range(0, RANGE_MAX);
      else obj_lo = $urandom_range(0, clamp_range(longint'(cfg_near) + 400));
      run_first = $urandom_range(0, len - 1);
      run_last  = $urandom_range(run_first, (run_first + 8 < len) ? run_first + 8 : len - 1);
      for (i = 0; i < len; i++) begin
         if (i >= run_first && i <= run_last) begin
            case ($urandom_range(0, 3))
               0:       v = clamp_range(longint'(obj_lo) + cfg_band);
               1:       v = clamp_range(longint'(obj_lo) + cfg_band + 1);
               default: v = clamp_range(longint'(obj_lo) + $urandom_range(0, cfg_band));
            endcase
         end else begin
            case ($urandom_range(0, 9))
               0: v = $urandom_range(0, RANGE_MAX);
               1: v = cfg_invalid;
               2: v = clamp_range(longint'(cfg_invalid) - 1);
               3: v = $urandom_range(cfg_invalid, RANGE_MAX);
               default:
                  v = $urandom_range(obj_lo,
                                     clamp_range(longint'(obj_lo) + cfg_band + 3000));
            endcase
         end
         queue_beam(v, i == len - 1);
      end
   endtask

   // Wait until every word is taken and every summary is back, then let
   // the block settle before the next register write.
   task automatic wait_drained();
      while (!(beam_words_q.size() == 0 && beams_accepted == beams_queued &&
               summary_q.size() == 0))
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int unsigned pick_sector(int unsigned lo_max, int unsigned extreme);
      return ($urandom_range(0, 7) == 0) ? extreme : $urandom_range(0, lo_max);
   endfunction

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int phase, target, len;
      int unsigned band, near_mm, inv;

      cfg_band        = OBJECT_BAND_RST;
      cfg_near        = NEAR_LIMIT_RST;
      cfg_invalid     = INVALID_LIMIT_RST;
      cfg_front_first = FRONT_FIRST_RST;
      cfg_front_end   = FRONT_END_RST;
      cfg_right_end   = RIGHT_END_RST;
      cfg_left_first  = LEFT_FIRST_RST;
      beam_fill = 0;
      scan_words = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: single-beam scans at the range extremes
      // (front and left sectors empty), a two-beam scan around the invalid
      // limit, then a scan whose closest return sits just above the near limit.
      queue_beam(0, 1'b1);
      queue_beam(RANGE_MAX, 1'b1);
      queue_beam(99999, 1'b0);
      queue_beam(100000, 1'b1);
      queue_beam(1501, 1'b0);
      queue_beam(1500 + 201, 1'b1);
      wait_drained();

      // Directed, small sectors: object edge with a no-return inside the
      // scan, an all-invalid scan with the limits at full scale, then a three-beam scan.
      write_setting(10, RANGE_MAX, RANGE_MAX, 1, 4, 3, 2);
      queue_beam(900, 1'b0);
      queue_beam(250, 1'b0);
      queue_beam(250, 1'b0);
      queue_beam(260, 1'b0);
      queue_beam(RANGE_MAX, 1'b0);
      queue_beam(700, 1'b0);
      queue_beam(250, 1'b1);
      queue_beam(RANGE_MAX, 1'b0);
      queue_beam(RANGE_MAX, 1'b1);
      queue_beam(3, 1'b0);
      queue_beam(4, 1'b0);
      queue_beam(4, 1'b1);
      wait_drained();

      // Random phases: low extremes, high extremes, then mixed settings.
      for (phase = 0; phase < 8; phase++) begin
         steady_flow = (phase == 2 || phase == 5);
         if (phase == 0) begin
            write_setting(0, 0, 0, 0, 0, 0, 0);
         end else if (phase == 1) begin
            write_setting(RANGE_MAX, RANGE_MAX, RANGE_MAX, 1023, 2047, 2047, 1023);
         end else begin
            case ($urandom_range(0, 3))
               0:       band = 0;
               1:       band = $urandom_range(0, 300);
               2:       band = $urandom_range(0, 5000);
               default: band = $urandom_range(0, RANGE_MAX);
            endcase
            case ($urandom_range(0, 3))
               0:       near_mm = $urandom_range(0, 2000);
               1:       near_mm = $urandom_range(1000, 20000);
               2:       near_mm = RANGE_MAX;
               default: near_mm = $urandom_range(0, RANGE_MAX);
            endcase
            case ($urandom_range(0, 3))
               0:       inv = $urandom_range(2000, RANGE_MAX);
               1:       inv = $urandom_range(20000, RANGE_MAX);
               2:       inv = RANGE_MAX;
               default: inv = $urandom_range(0, 5000);
            endcase
            write_setting(band, near_mm, inv, pick_sector(12, 1023),
                          pick_sector(24, ($urandom_range(0, 1) == 0) ? 1024 : 2047),
                          pick_sector(20, 2047), pick_sector(16, 1023));
         end
         target = beams_queued + 55;
         while (beams_queued < target) begin
            if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 16);
            else len = $urandom_range(17, 60);
            queue_scan(len);
         end
         wait_drained();
      end

      // Long scan with the default front and right sectors: overflow the store so the last
      // beam is dropped, then short scans to see the count rewind.
      steady_flow = 1'b0;
      write_setting($urandom_range(0, 600), NEAR_LIMIT_RST, INVALID_LIMIT_RST,
                    FRONT_FIRST_RST, FRONT_END_RST, RIGHT_END_RST,
                    $urandom_range(560, 639));
      queue_scan(NUM_BEAMS + 3);
      queue_scan(3);
      queue_scan(1);
      wait_drained();
      repeat (200) @(posedge clock);

      if (summary_q.size() != 0) begin
         mismatch_count++;
         $display("%0d summaries never arrived", summary_q.size());
      end

      $display("covered %0d beam words in %0d scans under %0d register settings",
               beams_accepted, scans_checked, settings_count);
      $display("longest scan %0d beams (store overflow included), %0d mismatches",
               longest_scan, mismatch_count);
      if (mismatch_count == 0) begin
         $display("laser_scan_obstacle_summary verification clean");
      end else begin
         $display("laser_scan_obstacle_summary verification failed");
      end
      $finish;
   end

endmodule

// ===== laser_scan_obstacle_summary.f =====
+incdir+sv
sv/lsos_pkg.sv
sv/lsos_ram.sv
sv/lsos_div.sv
sv/laser_scan_obstacle_summary.sv
sv/lsos_checker.sv
test/tb_laser_scan_obstacle_summary.sv
